// ===== design/kmg_pkg.sv =====
// shared constants, types and helpers of the k-way merge block
`default_nettype none

package kmg_pkg;

    localparam int CHANNELS            = 8;
    localparam int RECORDS_PER_CHANNEL = 256;

    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;
    localparam int CFG_W        = 4;
    localparam int CHAN_FIELD_W = 3;
    localparam int STATUS_W     = 2;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACT_W     = $clog2(CHANNELS + 1);
    localparam int SLOT_W    = (RECORDS_PER_CHANNEL > 1) ? $clog2(RECORDS_PER_CHANNEL) : 1;
    localparam int CNT_W     = $clog2(RECORDS_PER_CHANNEL + 1);
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int MEM_DEPTH = CHANNELS * (2 ** SLOT_W);

    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(8);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RECORDS_PER_CHANNEL);

    typedef logic [CH_W-1:0]  t_ch;
    typedef logic [ACT_W-1:0] t_act;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED    = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_EMITTED   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    // result of the shared key comparator
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    // channels taking part, register values above CHANNELS saturate
    function automatic t_act active_count(input logic [CFG_W-1:0] cfg);
        if (int'(cfg) > CHANNELS) begin
            return t_act'(CHANNELS);
        end
        return t_act'(cfg);
    endfunction

endpackage

`default_nettype wire

// ===== design/kmg_cmp.sv =====
// shared signed 64-bit key comparator
`default_nettype none

module kmg_cmp (
    input  logic signed [kmg_pkg::KEY_W-1:0] i_a,
    input  logic signed [kmg_pkg::KEY_W-1:0] i_b,
    output kmg_pkg::t_cmp                    o_res
);
    import kmg_pkg::*;

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

`default_nettype wire

// ===== design/kway_merge_group_by_key.sv =====
// top level: k-way merge of key-sorted channels with duplicate key grouping
//
//  channel   | direction | handshake          | contents
//  ----------+-----------+--------------------+------------------------------------------
//  request   | in        | i_valid / o_stall  | op, channel, record_key, record_value
//  result    | out       | o_valid / i_stall  | status, out_key, out_value,
//            |           |                    | source_channel, first_of_key
//  config    | in        | i_cfg_we           | channels_in_use (4 bits)
//
//  a load passes through accept, buffer write and result register in turn
//  a take probes one channel head per cycle through the single record memory read
//  port and the shared comparator over the n channels in use; when a group closes
//  first, a second pass looks for the smallest head to open the next group
//  synchronous active-low reset; the record memory is not cleared, only counters and control state
//  a held result in the output register does not block the next request
`default_nettype none

module kway_merge_group_by_key (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic [kmg_pkg::CHAN_FIELD_W-1:0]    i_channel,
    input  logic signed [kmg_pkg::KEY_W-1:0]    i_record_key,
    input  logic [kmg_pkg::VAL_W-1:0]           i_record_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [kmg_pkg::STATUS_W-1:0]        o_status,
    output logic signed [kmg_pkg::KEY_W-1:0]    o_out_key,
    output logic [kmg_pkg::VAL_W-1:0]           o_out_value,
    output logic [kmg_pkg::CHAN_FIELD_W-1:0]    o_source_channel,
    output logic                                o_first_of_key,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [kmg_pkg::CFG_W-1:0]           i_cfg_data
);
    import kmg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_cfg;

    // per-channel buffer pointers
    t_cnt                      r_fill [CHANNELS];
    t_cnt                      r_rcur [CHANNELS];

    // open key group
    logic                      r_gopen;
    logic signed [KEY_W-1:0]   r_gkey;
    t_ch                       r_gch;

    // latched load request
    logic [CHAN_FIELD_W-1:0]   r_in_ch;
    logic signed [KEY_W-1:0]   r_in_key;
    logic [VAL_W-1:0]          r_in_val;

    // scan sequencer
    logic                      r_min;       // 0: draining the open group, 1: min search
    logic                      r_probe_gc;  // group channel is probed first
    t_act                      r_idx;
    logic                      r_dv;
    t_ch                       r_dch;
    logic                      r_found;
    logic signed [KEY_W-1:0]   r_best_key;
    logic [VAL_W-1:0]          r_best_val;
    t_ch                       r_best_ch;
    t_status                   r_res_status;

    // record memory, key and value side by side
    logic [KEY_W+VAL_W-1:0]    r_mem [MEM_DEPTH];
    logic [KEY_W+VAL_W-1:0]    r_rd_data;

    // output register
    logic                      r_ovalid;
    t_status                   r_o_status;
    logic signed [KEY_W-1:0]   r_o_key;
    logic [VAL_W-1:0]          r_o_val;
    logic [CHAN_FIELD_W-1:0]   r_o_ch;
    logic                      r_o_first;

    t_act                      act_n;
    t_ch                       ld_ch;
    logic                      ld_ok;
    logic [ADDR_W-1:0]         wr_addr;
    t_ch                       iss_ch;
    logic                      iss_any;
    logic                      iss_hit;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]          rd_val;
    logic signed [KEY_W-1:0]   cmp_b;
    t_cmp                      cmp_res;
    logic                      match;
    logic                      take_best;
    logic                      scan_done;

    assign act_n = active_count(r_cfg);

    // load path: reject channels out of use and full buffers
    assign ld_ch   = t_ch'(r_in_ch);
    assign ld_ok   = (int'(r_in_ch) < int'(act_n)) && (r_fill[ld_ch] < FULL_COUNT);
    assign wr_addr = {ld_ch, r_fill[ld_ch][SLOT_W-1:0]};

    // probe issue: group channel first when a group is open, then 0 .. n-1
    always_comb begin
        iss_ch  = r_probe_gc ? r_gch : t_ch'(r_idx);
        iss_any = (r_state == S_SCAN) && (r_probe_gc || (r_idx < act_n));
        iss_hit = iss_any && (t_act'(iss_ch) < act_n) && (r_rcur[iss_ch] < r_fill[iss_ch]);
    end

    assign rd_addr = {iss_ch, r_rcur[iss_ch][SLOT_W-1:0]};
    assign rd_key  = r_rd_data[KEY_W+VAL_W-1:VAL_W];
    assign rd_val  = r_rd_data[VAL_W-1:0];

    // one comparator: against the group key while draining, against the best head otherwise
    assign cmp_b = r_min ? r_best_key : r_gkey;

    kmg_cmp u_cmp (
        .i_a   (rd_key),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    assign match     = r_dv && !r_min && cmp_res.eq;
    assign take_best = r_dv && r_min && (!r_found || cmp_res.lt);
    // nothing more to issue and the last probe has been judged
    assign scan_done = (r_state == S_SCAN) && !iss_any && !r_dv;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && ld_ok) begin
            r_mem[wr_addr] <= {r_in_key, r_in_val};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= CFG_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_fill[i] <= '0;
                r_rcur[i] <= '0;
            end
            r_gopen    <= 1'b0;
            r_gkey     <= '0;
            r_gch      <= '0;
            r_min      <= 1'b0;
            r_probe_gc <= 1'b0;
            r_idx      <= '0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // in the finish state the output register is reloaded instead
            if (r_ovalid && !i_stall && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            r_dv  <= iss_hit;
            r_dch <= iss_ch;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in_ch  <= i_channel;
                        r_in_key <= i_record_key;
                        r_in_val <= i_record_value;
                        if (t_op'(i_op) == OP_TAKE) begin
                            r_min      <= !r_gopen;
                            r_probe_gc <= r_gopen;
                            r_idx      <= '0;
                            r_found    <= 1'b0;
                            r_state    <= S_SCAN;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    if (ld_ok) begin
                        r_fill[ld_ch] <= r_fill[ld_ch] + 1'b1;
                        r_res_status  <= ST_LOADED;
                    end else begin
                        r_res_status  <= ST_REJECTED;
                    end
                    r_state <= S_FIN;
                end
                S_SCAN: begin
                    if (iss_any) begin
                        if (r_probe_gc) begin
                            r_probe_gc <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (match) begin
                        // group continues from this channel; in-flight probe is dropped
                        r_best_key   <= rd_key;
                        r_best_val   <= rd_val;
                        r_best_ch    <= r_dch;
                        r_res_status <= ST_EMITTED;
                        r_state      <= S_FIN;
                    end else if (take_best) begin
                        r_best_key <= rd_key;
                        r_best_val <= rd_val;
                        r_best_ch  <= r_dch;
                        r_found    <= 1'b1;
                    end else if (scan_done) begin
                        if (!r_min) begin
                            // group exhausted: close it and look for the smallest head
                            r_min   <= 1'b1;
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_gopen <= 1'b0;
                        end else begin
                            r_res_status <= r_found ? ST_EMITTED : ST_EXHAUSTED;
                            r_state      <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_res_status;
                        if (r_res_status == ST_EMITTED) begin
                            r_o_key              <= r_best_key;
                            r_o_val              <= r_best_val;
                            r_o_ch               <= CHAN_FIELD_W'(r_best_ch);
                            r_o_first            <= r_min;
                            r_rcur[r_best_ch]    <= r_rcur[r_best_ch] + 1'b1;
                            r_gch                <= r_best_ch;
                            if (r_min) begin
                                r_gopen <= 1'b1;
                                r_gkey  <= r_best_key;
                            end
                        end else begin
                            r_o_key   <= '0;
                            r_o_val   <= '0;
                            r_o_ch    <= '0;
                            r_o_first <= 1'b0;
                            if (r_res_status == ST_EXHAUSTED) begin
                                r_gopen <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_out_key        = r_o_key;
    assign o_out_value      = r_o_val;
    assign o_source_channel = r_o_ch;
    assign o_first_of_key   = r_o_first;

endmodule

`default_nettype wire

// ===== tb/tb_kway_merge_group_by_key.sv =====
// self-checking testbench of the k-way merge block with key grouping
module tb_kway_merge_group_by_key;
    import kmg_pkg::*;

    typedef logic signed [KEY_W-1:0] t_key;

    // one request as it goes onto the input port
    typedef struct packed {
        t_op                     op;
        logic [CHAN_FIELD_W-1:0] channel;
        t_key                    key;
        logic [VAL_W-1:0]        value;
    } t_merge_req;

    // one result as it leaves the output port
    typedef struct packed {
        t_status                 status;
        t_key                    key;
        logic [VAL_W-1:0]        value;
        logic [CHAN_FIELD_W-1:0] src;
        logic                    first_key;
    } t_merge_rsp;

    localparam int TOTAL_REQUESTS   = 1850;
    localparam int QUIET_REQUESTS   = 150;
    localparam int FULL_TEST_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;

    // ports of the block; the inputs are known from time zero
    logic                    i_clk;
    logic                    i_rst_n          = 1'b0;
    logic                    i_valid          = 1'b0;
    logic                    o_stall;
    logic                    i_op             = 1'b0;
    logic [CHAN_FIELD_W-1:0] i_channel        = '0;
    t_key                    i_record_key     = '0;
    logic [VAL_W-1:0]        i_record_value   = '0;
    logic                    o_valid;
    logic                    i_stall          = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    t_key                    o_out_key;
    logic [VAL_W-1:0]        o_out_value;
    logic [CHAN_FIELD_W-1:0] o_source_channel;
    logic                    o_first_of_key;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data       = '0;

    kway_merge_group_by_key u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_channel        (i_channel),
        .i_record_key     (i_record_key),
        .i_record_value   (i_record_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_out_key        (o_out_key),
        .o_out_value      (o_out_value),
        .o_source_channel (o_source_channel),
        .o_first_of_key   (o_first_of_key),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // merge predictor: its own copy of the channel buffers and group state
    // ------------------------------------------------------------------
    t_key             rec_key   [CHANNELS][RECORDS_PER_CHANNEL];
    logic [VAL_W-1:0] rec_value [CHANNELS][RECORDS_PER_CHANNEL];
    int unsigned      rec_fill  [CHANNELS] = '{default: 0};
    int unsigned      rec_read  [CHANNELS] = '{default: 0};
    t_key             grp_key   = '0;
    bit               grp_open  = 1'b0;
    int unsigned      grp_ch    = 0;
    int unsigned      chan_cfg  = 8;    // register value after reset

    // register values above the channel count saturate, zero means none
    function automatic int unsigned channels_taking_part();
        return (chan_cfg > CHANNELS) ? CHANNELS : chan_cfg;
    endfunction

    function automatic bit head_ready(int unsigned c);
        return c < channels_taking_part() && rec_read[c] < rec_fill[c];
    endfunction

    // emit the head record of a channel and advance past it
    function automatic t_merge_rsp pop_head(int unsigned c, logic opens_group);
        t_merge_rsp r;
        r.status    = ST_EMITTED;
        r.key       = rec_key[c][rec_read[c]];
        r.value     = rec_value[c][rec_read[c]];
        r.src       = CHAN_FIELD_W'(c);
        r.first_key = opens_group;
        rec_read[c]++;
        return r;
    endfunction

    function automatic t_merge_rsp predict_merge_result(t_merge_req rq);
        t_merge_rsp  r;
        int unsigned n;
        int unsigned ch;
        int          best;
        r        = '0;
        r.status = ST_LOADED;
        n        = channels_taking_part();
        ch       = rq.channel;

        if (rq.op == OP_LOAD) begin
            // channel out of use or buffer full; read slots are never reused
            if (ch >= n || rec_fill[ch] >= RECORDS_PER_CHANNEL) begin
                r.status = ST_REJECTED;
            end else begin
                rec_key[ch][rec_fill[ch]]   = rq.key;
                rec_value[ch][rec_fill[ch]] = rq.value;
                rec_fill[ch]++;
            end
            return r;
        end

        // an open group drains its own channel first, then the lowest one
        if (grp_open) begin
            if (head_ready(grp_ch) && rec_key[grp_ch][rec_read[grp_ch]] == grp_key) begin
                return pop_head(grp_ch, 1'b0);
            end
            for (int unsigned c = 0; c < n; c++) begin
                if (head_ready(c) && rec_key[c][rec_read[c]] == grp_key) begin
                    grp_ch = c;
                    return pop_head(c, 1'b0);
                end
            end
            grp_open = 1'b0;
        end

        // new group: smallest signed head key, ties to the lowest channel
        best = -1;
        for (int unsigned c = 0; c < n; c++) begin
            if (head_ready(c) &&
                (best < 0 || rec_key[c][rec_read[c]] < rec_key[best][rec_read[best]])) begin
                best = c;
            end
        end
        if (best < 0) begin
            r.status = ST_EXHAUSTED;
            return r;
        end
        grp_open = 1'b1;
        grp_ch   = best;
        grp_key  = rec_key[best][rec_read[best]];
        return pop_head(best, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping between stimulus, driver and monitor
    // ------------------------------------------------------------------
    // both queues fill at the front and drain from the back
    t_merge_req  request_queue[$];      // requests not yet offered
    t_merge_rsp  pending_results[$];    // expected results in order
    int unsigned n_queued      = 0;
    int unsigned drv_issued    = 0;     // requests raised on the port
    int unsigned n_accepted    = 0;     // requests taken by the block
    int unsigned idle_pct      = 0;     // chance of an idle burst per cycle
    bit          quiet_tail    = 1'b0;  // no idling at the end of the run
    int unsigned hold_requests = 0;     // long receiver hold-offs asked for
    int unsigned mismatches    = 0;
    int unsigned n_loads_ok    = 0;
    int unsigned n_rejected    = 0;
    int unsigned n_emitted     = 0;
    int unsigned n_groups      = 0;
    int unsigned n_exhausted   = 0;
    int unsigned n_cfg_writes  = 0;

    // ------------------------------------------------------------------
    // request driver: changes inputs at the falling edge only
    // ------------------------------------------------------------------
    int unsigned req_gap = 0;

    always @(negedge i_clk) begin : request_driver
        t_merge_req rq;
        if (!i_rst_n || (i_valid && n_accepted != drv_issued)) begin
            // in reset, or the offered request is still stalled: keep it as is
        end else if (req_gap != 0) begin
            req_gap--;
            i_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(99, 0) < idle_pct) begin
            // idle burst of random length
            req_gap = $urandom_range(7, 0);
            i_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
            rq = request_queue.pop_back();
            i_op           <= rq.op;
            i_channel      <= rq.channel;
            i_record_key   <= rq.key;
            i_record_value <= rq.value;
            drv_issued++;
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result stall: random bursts plus an occasional long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_served = 0;
    int unsigned stall_left  = 0;

    always @(negedge i_clk) begin : result_stall
        if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = LONG_HOLD_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet_tail && $urandom_range(99, 0) < idle_pct) begin
            stall_left = $urandom_range(7, 0);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts at request acceptance, checks at result acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : merge_monitor
        t_merge_rsp exp_rsp;
        t_merge_rsp got_rsp;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                exp_rsp = predict_merge_result('{op: t_op'(i_op), channel: i_channel,
                                                 key: i_record_key, value: i_record_value});
                case (exp_rsp.status)
                    ST_LOADED:    n_loads_ok++;
                    ST_REJECTED:  n_rejected++;
                    ST_EMITTED: begin
                        n_emitted++;
                        if (exp_rsp.first_key) begin
                            n_groups++;
                        end
                    end
                    default:      n_exhausted++;
                endcase
                pending_results.push_front(exp_rsp);
                n_accepted++;
            end
            if (o_valid && !i_stall) begin
                got_rsp = '{status: t_status'(o_status), key: o_out_key, value: o_out_value,
                            src: o_source_channel, first_key: o_first_of_key};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: status %0d key %0d value %h src %0d first %b",
                                 got_rsp.status, got_rsp.key, got_rsp.value, got_rsp.src,
                                 got_rsp.first_key);
                    end
                end else begin
                    exp_rsp = pending_results.pop_back();
                    if (got_rsp !== exp_rsp) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected: status %0d key %0d value %h src %0d first %b",
                                     exp_rsp.status, exp_rsp.key, exp_rsp.value, exp_rsp.src,
                                     exp_rsp.first_key);
                            $display("  actual:   status %0d key %0d value %h src %0d first %b",
                                     got_rsp.status, got_rsp.key, got_rsp.value, got_rsp.src,
                                     got_rsp.first_key);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_request(t_op op, int unsigned ch, t_key key, logic [VAL_W-1:0] value);
        request_queue.push_front('{op: op, channel: CHAN_FIELD_W'(ch), key: key, value: value});
        n_queued++;
    endtask

    // the channel, key and value of a take are don't-care, so they are random
    task automatic push_take();
        push_request(OP_TAKE, $urandom_range(7, 0), $signed({$urandom, $urandom}), $urandom);
    endtask

    // every offered request taken and every result returned
    task automatic wait_idle();
        while (request_queue.size() != 0 || n_accepted != drv_issued ||
               pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // register writes only with the block idle
    task automatic write_channels_in_use(logic [CFG_W-1:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        chan_cfg = v;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one round: sorted loads from a small shared key pool so that keys repeat
    // across channels, takes mixed in between, and a little noise
    task automatic queue_merge_round();
        int unsigned left [CHANNELS];
        int unsigned pos  [CHANNELS];
        int unsigned n;
        int unsigned loads;
        int unsigned takes;
        int unsigned nkeys;
        int unsigned c;
        int unsigned pick;
        t_key        base;
        t_key        step;

        if (!quiet_tail) begin
            pick = $urandom_range(2, 0);
            idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
        end

        // most rounds pick a new setting; some keep it so groups stay open across
        if ($urandom_range(9, 0) < 7) begin
            pick = $urandom_range(9, 0);
            if (pick == 0) begin
                write_channels_in_use('0);
            end else if (pick == 1) begin
                write_channels_in_use(CFG_W'($urandom_range(15, 9)));
            end else begin
                write_channels_in_use(CFG_W'($urandom_range(8, 1)));
            end
        end

        n     = channels_taking_part();
        nkeys = $urandom_range(6, 2);
        step  = t_key'($urandom_range(1000, 1));
        case ($urandom_range(9, 0))
            0:       base = {1'b1, {(KEY_W-1){1'b0}}};
            1:       base = {1'b0, {(KEY_W-1){1'b1}}} - t_key'(nkeys) * step;
            default: base = $signed({$urandom, $urandom}) >>> 1;
        endcase

        loads = 0;
        for (int unsigned k = 0; k < CHANNELS; k++) begin
            left[k] = (k < n) ? $urandom_range(4, 0) : 0;
            pos[k]  = 0;
            loads += left[k];
        end
        // usually drain to exhaustion, sometimes leave records and a group behind
        if ($urandom_range(3, 0) == 0) begin
            takes = (loads > 2) ? loads - $urandom_range(2, 0) : loads;
        end else begin
            takes = loads + $urandom_range(2, 1);
        end

        while (loads + takes != 0) begin
            if ($urandom_range(99, 0) < 6) begin
                push_request(t_op'($urandom_range(1, 0)), $urandom_range(7, 0),
                             $signed({$urandom, $urandom}), $urandom);
            end
            if (loads == 0 || (takes != 0 && $urandom_range(3, 0) == 0)) begin
                push_take();
                takes--;
            end else begin
                do begin
                    c = $urandom_range(CHANNELS - 1, 0);
                end while (left[c] == 0);
                push_request(OP_LOAD, c, base + t_key'(pos[c]) * step, $urandom);
                // keys stay ascending inside a channel, repeats allowed
                if (pos[c] + 1 < nkeys) begin
                    pos[c] += $urandom_range(1, 0);
                end
                left[c]--;
                loads--;
            end
        end
    endtask

    initial begin : stimulus
        t_key base;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: key extremes, ties, groups across channels
        push_request(OP_LOAD, 0, 64'sh8000_0000_0000_0000, 32'h0000_0000);
        push_request(OP_LOAD, 7, 64'sh7fff_ffff_ffff_ffff, 32'hffff_ffff);
        push_request(OP_LOAD, 3, 64'sd5, 32'h0000_0a0a);
        push_request(OP_LOAD, 1, 64'sd5, 32'h0000_0b0b);
        push_request(OP_LOAD, 3, 64'sd5, 32'h0000_0c0c);
        push_take();    // most negative key from channel 0
        push_take();    // tie on 5 goes to channel 1
        push_take();    // group moves to channel 3
        push_take();
        push_take();    // largest key opens a new group
        push_take();    // nothing left
        // a record loaded with the open group key joins the group
        push_request(OP_LOAD, 2, 64'sd10, 32'h1234_5678);
        push_take();
        push_request(OP_LOAD, 4, 64'sd10, 32'h8765_4321);
        push_take();
        push_take();
        // an unsorted channel is still taken in order from its head
        push_request(OP_LOAD, 5, 64'sd20, 32'h0000_0020);
        push_request(OP_LOAD, 5, -64'sd3, 32'h0000_0003);
        push_take();
        push_take();
        push_take();

        // zero channels in use: loads rejected, takes exhausted
        write_channels_in_use(4'd0);
        push_request(OP_LOAD, 0, 64'sd1, 32'h0000_0001);
        push_take();
        // register above the channel count acts as all channels
        write_channels_in_use(4'd15);
        push_request(OP_LOAD, 7, 64'sd42, 32'h0000_0042);
        push_take();
        // a single channel: others rejected
        write_channels_in_use(4'd1);
        push_request(OP_LOAD, 1, 64'sd7, 32'h0000_0007);
        push_request(OP_LOAD, 0, 64'sd7, 32'h0000_0077);
        push_take();

        // random rounds; midway one channel is filled past its capacity while
        // the receiver holds off for a long stretch, so the block backs up
        while (n_queued < TOTAL_REQUESTS - QUIET_REQUESTS) begin
            if (n_queued >= FULL_TEST_AT && hold_requests == 0) begin
                write_channels_in_use(4'd8);
                idle_pct = 10;
                hold_requests++;
                base = $signed({$urandom, $urandom}) >>> 2;
                for (int i = 0; i <= RECORDS_PER_CHANNEL; i++) begin
                    push_request(OP_LOAD, 6, base + t_key'(i / 2), $urandom);
                end
                for (int i = 0; i < RECORDS_PER_CHANNEL + 12; i++) begin
                    push_take();
                end
                // drained slots are not reused: still rejected
                push_request(OP_LOAD, 6, base + t_key'(RECORDS_PER_CHANNEL), $urandom);
            end
            queue_merge_round();
        end

        // last part of the run without any idling
        quiet_tail = 1'b1;
        idle_pct   = 0;
        while (n_queued < TOTAL_REQUESTS) begin
            queue_merge_round();
        end

        wait_idle();
        repeat (40) @(posedge i_clk);

        $display("ran %0d requests over %0d register writes: %0d loads stored, %0d rejected",
                 n_accepted, n_cfg_writes, n_loads_ok, n_rejected);
        $display("%0d records emitted in %0d key groups, %0d takes found nothing left",
                 n_emitted, n_groups, n_exhausted);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
